/* rtl/core/tiri_pkg.sv */
// Shared types and constants of the table interpolated refractive index core.
// Used by tiri_div and table_interpolated_refractive_index_core; no dependencies.
`default_nettype none
package tiri_pkg;

   localparam int TABLE_DEPTH_DEFAULT = 1024;
   localparam int FRAC_BITS           = 24;

   // 1e7 * 2^28 / 2^32: the quotient saturates when the wavenumber is at most this.
   localparam logic [31:0] SAT_LIMIT = 32'd625000;
   // Twice SAT_LIMIT: first partial remainder of the wavelength division.
   localparam logic [32:0] WL_REM_INIT = 33'd1250000;

   localparam logic [5:0] WL_DIV_STEPS   = 6'd32;
   localparam logic [5:0] FRAC_DIV_STEPS = 6'd25;

   typedef enum logic {
      CMD_WRITE = 1'b0,
      CMD_QUERY = 1'b1
   } command_type;

   typedef enum logic [1:0] {
      STATUS_INTERP = 2'd0,
      STATUS_FIRST  = 2'd1,
      STATUS_LAST   = 2'd2,
      STATUS_ZERO   = 2'd3
   } status_type;

   typedef struct packed {
      logic               command;
      logic [9:0]         entry_index;
      logic [31:0]        entry_wavelength;
      logic signed [31:0] entry_real;
      logic signed [31:0] entry_imag;
      logic [31:0]        query_wavenumber;
   } req_type;

   typedef struct packed {
      logic signed [31:0] real_part;
      logic signed [31:0] imag_part;
      logic [1:0]         status;
   } rsp_type;

   typedef struct packed {
      logic [31:0]        wavelength;
      logic signed [31:0] re;
      logic signed [31:0] im;
   } entry_type;

   typedef struct packed {
      logic       start;
      logic [5:0] steps;
   } div_req_type;

endpackage
`default_nettype wire

/* rtl/core/tiri_div.sv */
// Restoring divider, one quotient bit per cycle, shared by the wavelength
// and fraction divisions. Depends on tiri_pkg.
`default_nettype none
module tiri_div (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire tiri_pkg::div_req_type div_req,
   input  wire logic [32:0]          num,
   input  wire logic [31:0]          den,
   output logic                      done,
   output logic [31:0]               quot
);

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [32:0] rem_ff, rem_in;
   logic [31:0] den_ff, den_in;
   logic [31:0] quot_ff, quot_in;
   logic        bit_q;
   logic [32:0] diff;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quot_in = quot_ff;
      bit_q   = (rem_ff >= {1'b0, den_ff});
      diff    = bit_q ? (rem_ff - {1'b0, den_ff}) : rem_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = div_req.steps;
         rem_in  = num;
         den_in  = den;
         quot_in = '0;
      end else if (busy_ff) begin
         // The remainder stays below the divisor, so the shift fits in 33 bits.
         rem_in  = {diff[31:0], 1'b0};
         quot_in = {quot_ff[30:0], bit_q};
         cnt_in  = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      quot_ff <= quot_in;
   end

   assign done = done_ff;
   assign quot = quot_ff;

endmodule
`default_nettype wire

/* rtl/core/table_interpolated_refractive_index_core.sv */
// Table interpolated refractive index core: one entry memory, a linear scan,
// a shared divider and a blend multiplier. Depends on tiri_pkg and tiri_div.
//
// Usage: req carries one beat per command. A write beat stores one entry
// (wavelength, real, imag) at entry_index and gives no result; indexes at
// or beyond TABLE_DEPTH are dropped. A query beat converts the wavenumber
// to a wavelength (skipped when it saturates; a zero wavenumber gives a
// STATUS_ZERO result with no scan), then scans entries 0..table_count-1
// (table_count taken as 1..TABLE_DEPTH) in order, one memory read per
// cycle, for the first wavelength not below it. Inside the table, a
// fraction division and the blend multiplies follow. req_stall is high
// while a query is at work; one query at a time. Each query gives one
// rsp beat, held in an output register until taken; a stalled result
// holds the block in its last step, not the result. csr writes table_count
// (reset 1) and are taken in any cycle; write only while idle. Reset is
// synchronous; the table memory is not cleared and entries must be
// written before they are read.
`default_nettype none
module table_interpolated_refractive_index_core #(
   parameter int TABLE_DEPTH = tiri_pkg::TABLE_DEPTH_DEFAULT
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire tiri_pkg::req_type req_payload,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output tiri_pkg::rsp_type      rsp_payload,
   input  wire logic              csr_valid,
   output logic                   csr_ready,
   input  wire logic [10:0]       csr_data
);

   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int CW = $clog2(TABLE_DEPTH + 1);

   typedef enum logic [6:0] {
      ST_IDLE = 7'b0000001,
      ST_DIV1 = 7'b0000010,
      ST_SCAN = 7'b0000100,
      ST_DIV2 = 7'b0001000,
      ST_MULR = 7'b0010000,
      ST_MULI = 7'b0100000,
      ST_DONE = 7'b1000000
   } state_type;

   tiri_pkg::entry_type mem [TABLE_DEPTH];

   state_type           state_ff, state_in;
   logic [10:0]         count_ff;
   logic [CW-1:0]       n_use;
   logic [AW-1:0]       n_last;
   logic [31:0]         lam_ff, lam_in;
   logic [CW-1:0]       issue_ff, issue_in;
   logic                rd_valid_ff, rd_valid_in;
   logic [AW-1:0]       rd_idx_ff;
   tiri_pkg::entry_type rd_data_ff;
   tiri_pkg::entry_type prev_ff, prev_in;
   tiri_pkg::entry_type e1_ff, e1_in, e2_ff, e2_in;
   logic signed [58:0]  prod_ff, prod_in;
   logic signed [31:0]  res_re_ff, res_re_in, res_im_ff, res_im_in;
   logic [1:0]          status_ff, status_in;
   logic                rsp_valid_ff, rsp_valid_in;
   tiri_pkg::rsp_type   rsp_ff, rsp_in;
   logic                req_take, wr_en;
   tiri_pkg::div_req_type div_req;
   logic [32:0]         div_num;
   logic [31:0]         div_den;
   logic                div_done;
   logic [31:0]         div_quot;
   logic signed [32:0]  diff_re, diff_im;
   logic signed [25:0]  g_s;

   function automatic logic signed [31:0] blend_round(input logic signed [31:0] v1,
                                                      input logic signed [58:0] prod);
      logic signed [58:0] sum;
      logic signed [58:0] q;
      sum = $signed({{3{v1[31]}}, v1, 24'b0}) + prod;
      q   = sum >>> tiri_pkg::FRAC_BITS;
      // Truncate toward zero: negative sums with a remainder move up by one.
      if (sum[58] && (sum[23:0] != 24'd0)) q = q + 59'sd1;
      return q[31:0];
   endfunction

   always_comb begin
      if (count_ff == 11'd0) n_use = CW'(1);
      else if (32'(count_ff) > TABLE_DEPTH) n_use = CW'(TABLE_DEPTH);
      else n_use = CW'(count_ff);
   end
   assign n_last = AW'(n_use - CW'(1));

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign wr_en     = req_take && (req_payload.command == tiri_pkg::CMD_WRITE)
                      && (32'(req_payload.entry_index) < TABLE_DEPTH);
   assign csr_ready = 1'b1;

   assign diff_re = {e2_ff.re[31], e2_ff.re} - {e1_ff.re[31], e1_ff.re};
   assign diff_im = {e2_ff.im[31], e2_ff.im} - {e1_ff.im[31], e1_ff.im};
   assign g_s     = $signed({1'b0, div_quot[24:0]});

   always_comb begin
      state_in     = state_ff;
      lam_in       = lam_ff;
      issue_in     = issue_ff;
      rd_valid_in  = 1'b0;
      prev_in      = prev_ff;
      e1_in        = e1_ff;
      e2_in        = e2_ff;
      prod_in      = prod_ff;
      res_re_in    = res_re_ff;
      res_im_in    = res_im_ff;
      status_in    = status_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      div_req      = '0;
      div_num      = tiri_pkg::WL_REM_INIT;
      div_den      = req_payload.query_wavenumber;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take && (req_payload.command == tiri_pkg::CMD_QUERY)) begin
               issue_in = '0;
               if (req_payload.query_wavenumber == 32'd0) begin
                  res_re_in = '0;
                  res_im_in = '0;
                  status_in = tiri_pkg::STATUS_ZERO;
                  state_in  = ST_DONE;
               end else if (req_payload.query_wavenumber <= tiri_pkg::SAT_LIMIT) begin
                  lam_in   = 32'hFFFF_FFFF;
                  state_in = ST_SCAN;
               end else begin
                  div_req.start = 1'b1;
                  div_req.steps = tiri_pkg::WL_DIV_STEPS;
                  state_in      = ST_DIV1;
               end
            end
         end
         ST_DIV1: begin
            if (div_done) begin
               lam_in   = div_quot;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (rd_valid_ff && (rd_data_ff.wavelength >= lam_ff)) begin
               if (rd_idx_ff == '0) begin
                  res_re_in = rd_data_ff.re;
                  res_im_in = rd_data_ff.im;
                  status_in = tiri_pkg::STATUS_FIRST;
                  state_in  = ST_DONE;
               end else begin
                  e1_in         = prev_ff;
                  e2_in         = rd_data_ff;
                  div_req.start = 1'b1;
                  div_req.steps = tiri_pkg::FRAC_DIV_STEPS;
                  div_num       = {1'b0, lam_ff - prev_ff.wavelength};
                  div_den       = rd_data_ff.wavelength - prev_ff.wavelength;
                  state_in      = ST_DIV2;
               end
            end else if (rd_valid_ff && (rd_idx_ff == n_last)) begin
               res_re_in = rd_data_ff.re;
               res_im_in = rd_data_ff.im;
               status_in = tiri_pkg::STATUS_LAST;
               state_in  = ST_DONE;
            end else begin
               if (rd_valid_ff) prev_in = rd_data_ff;
               if (issue_ff < n_use) begin
                  rd_valid_in = 1'b1;
                  issue_in    = issue_ff + CW'(1);
               end
            end
         end
         ST_DIV2: begin
            if (div_done) begin
               prod_in  = diff_re * g_s;
               state_in = ST_MULR;
            end
         end
         ST_MULR: begin
            res_re_in = blend_round(e1_ff.re, prod_ff);
            prod_in   = diff_im * g_s;
            state_in  = ST_MULI;
         end
         ST_MULI: begin
            res_im_in = blend_round(e1_ff.im, prod_ff);
            status_in = tiri_pkg::STATUS_INTERP;
            state_in  = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in      = 1'b1;
               rsp_in.real_part  = res_re_ff;
               rsp_in.imag_part  = res_im_ff;
               rsp_in.status     = status_ff;
               state_in          = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[AW'(req_payload.entry_index)] <= '{wavelength: req_payload.entry_wavelength,
                                                re: req_payload.entry_real,
                                                im: req_payload.entry_imag};
      end
      rd_data_ff <= mem[issue_ff[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= 11'd1;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         issue_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rd_valid_ff  <= rd_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         issue_ff     <= issue_in;
         if (csr_valid && csr_ready) count_ff <= csr_data;
      end
      rd_idx_ff <= issue_ff[AW-1:0];
      lam_ff    <= lam_in;
      prev_ff   <= prev_in;
      e1_ff     <= e1_in;
      e2_ff     <= e2_in;
      prod_ff   <= prod_in;
      res_re_ff <= res_re_in;
      res_im_ff <= res_im_in;
      status_ff <= status_in;
      rsp_ff    <= rsp_in;
   end

   tiri_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .num     (div_num),
      .den     (div_den),
      .done    (div_done),
      .quot    (div_quot)
   );

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // A read beat in the scan never lies beyond the entries in use.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN && rd_valid_ff) |-> (rd_idx_ff <= n_last))
      else $error("scan read beyond table_count");

   // The divider only finishes while a division is awaited.
   assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_DIV1 || state_ff == ST_DIV2))
      else $error("divider finished outside a division state");

   // The interpolation window is never empty, so the divisor is nonzero.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV2) |-> (e1_ff.wavelength < e2_ff.wavelength))
      else $error("empty interpolation window");

   // A query reaches the result register only from the final step.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_DONE))
      else $error("result loaded outside the final step");

endmodule
`default_nettype wire
